/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the density transform.
// Depends on nothing; each macro takes the clock and active-low reset by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Condition must never be seen at an edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`endif

/* hw/rtl/rgbhsd_pkg.sv */
// Shared types, constants and elaboration-time table functions for the
// RGB to HSD density transform. Depends on nothing.
package rgbhsd_pkg;

  localparam int FRAC_BITS_DEF = 13;
  localparam int LOG_FRAC      = 30;
  localparam logic [31:0] LN2_Q30   = 32'd744261118;
  localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;

  typedef struct packed {
    logic [7:0] channel_zero;
    logic [7:0] channel_one;
    logic [7:0] channel_two;
  } pixel_t;

  typedef struct packed {
    logic        [15:0] mean_density;
    logic signed [15:0] chroma_x;
    logic signed [15:0] chroma_y;
  } hsd_t;

  // log2(x) for x in 1..255 with LOG_FRAC fraction bits, truncated.
  // Only ever called with constant arguments to build the density table.
  function automatic logic [63:0] log2_q30(input int unsigned x);
    int unsigned n;
    logic [63:0] m;
    logic [63:0] fr;
    n  = 0;
    fr = '0;
    for (int i = 0; i < 7; i++) begin
      if ((x >> (n + 1)) != 0) n = n + 1;
    end
    m = 64'(x) << (LOG_FRAC - n);
    for (int i = 0; i < LOG_FRAC; i++) begin
      m  = (m * m) >> LOG_FRAC;
      fr = fr << 1;
      if (m >= (64'd2 << LOG_FRAC)) begin
        m     = m >> 1;
        fr[0] = 1'b1;
      end
    end
    return (64'(n) << LOG_FRAC) | fr;
  endfunction

  // Optical density -ln(v/255) of a clamped byte, frac fraction bits, rounded.
  function automatic logic [63:0] density_calc(input int unsigned v, input int frac);
    int unsigned vc;
    logic [63:0] diff;
    logic [63:0] prod;
    vc = v;
    if (vc == 0) vc = 1;
    if (vc == 255) vc = 254;
    diff = log2_q30(255) - log2_q30(vc);
    prod = diff * 64'(LN2_Q30);
    return (prod + (64'd1 << (2 * LOG_FRAC - 1 - frac))) >> (2 * LOG_FRAC - frac);
  endfunction

endpackage

/* hw/rtl/rgbhsd_div_cell.sv */
// One cell of the restoring-division chain: one quotient bit per lane.
// Depends on nothing; instantiated in a row by the top level.
module rgbhsd_div_cell #(
  parameter int RW  = 33,
  parameter int QW  = 15,
  parameter int SBW = 37
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  logic [RW-1:0]  dsh_i,
  input  logic [RW-1:0]  rx_i,
  input  logic [RW-1:0]  ry_i,
  input  logic [QW-1:0]  qx_i,
  input  logic [QW-1:0]  qy_i,
  input  logic [SBW-1:0] side_i,
  output logic           valid_o,
  output logic [RW-1:0]  dsh_o,
  output logic [RW-1:0]  rx_o,
  output logic [RW-1:0]  ry_o,
  output logic [QW-1:0]  qx_o,
  output logic [QW-1:0]  qy_o,
  output logic [SBW-1:0] side_o
);

  logic          valid_r;
  logic [RW-1:0] dsh_r, rx_r, ry_r;
  logic [QW-1:0] qx_r, qy_r;
  logic [SBW-1:0] side_r;
  logic          gex, gey;
  logic [RW-1:0] rx_nxt, ry_nxt;

  assign gex    = (rx_i >= dsh_i);
  assign gey    = (ry_i >= dsh_i);
  assign rx_nxt = gex ? (rx_i - dsh_i) : rx_i;
  assign ry_nxt = gey ? (ry_i - dsh_i) : ry_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // Payload advances every cycle; the valid bit marks live beats.
  always_ff @(posedge clk) begin
    dsh_r  <= dsh_i >> 1;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    qx_r   <= {qx_i[QW-2:0], gex};
    qy_r   <= {qy_i[QW-2:0], gey};
    side_r <= side_i;
  end

  assign valid_o = valid_r;
  assign dsh_o   = dsh_r;
  assign rx_o    = rx_r;
  assign ry_o    = ry_r;
  assign qx_o    = qx_r;
  assign qy_o    = qy_r;
  assign side_o  = side_r;

endmodule

/* hw/rtl/rgbhsd_front.sv */
// Front pipeline: density lookup, channel swap, sums, sqrt3 product and the
// reciprocal multiply for the mean. Depends on rgbhsd_pkg.
module rgbhsd_front #(
  parameter int FRAC_BITS = rgbhsd_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  input  rgbhsd_pkg::pixel_t         pixel_i,
  input  logic                       channel_order_i,
  output logic                       valid_o,
  output logic [2*FRAC_BITS+6:0]     xnum_o,
  output logic [2*FRAC_BITS+6:0]     ynum_o,
  output logic [2*FRAC_BITS+6:0]     dsh_o,
  output logic [2*FRAC_BITS+10:0]    side_o
);
  import rgbhsd_pkg::*;

  localparam int DW  = FRAC_BITS + 3;
  localparam int SW  = DW + 2;
  localparam int QW  = FRAC_BITS + 2;
  localparam int RW  = SW + QW;
  localparam int K   = LOG_FRAC - FRAC_BITS;
  localparam int PW  = DW + 31;
  localparam logic [SW-1:0] MEAN_RECIP = SW'((2 ** SW) / 3);

  logic [DW-1:0] lut [256];

  for (genvar g = 0; g < 256; g++) begin : g_lut
    localparam logic [DW-1:0] ENTRY = DW'(density_calc(g, FRAC_BITS));
    assign lut[g] = ENTRY;
  end

  // Stage A: table lookup
  logic          a_valid_r;
  logic [DW-1:0] a_dr_r, a_dg_r, a_db_r;

  // Stage B: sum, numerator, difference product
  logic          b_valid_r;
  logic [SW-1:0] b_s_r;
  logic [RW-1:0] b_xnum_r;
  logic [PW-1:0] b_mag_r;
  logic          b_neg_r;

  // Stage C: scaled y numerator, mean estimate
  logic          c_valid_r;
  logic [SW-1:0] c_s_r, c_sp1_r, c_q0_r;
  logic [RW-1:0] c_xnum_r, c_ynum_r;
  logic          c_neg_r;

  logic [DW-1:0]   dr_nxt, db_nxt;
  logic [SW-1:0]   s_nxt;
  logic [DW+1:0]   dr3;
  logic            neg_nxt;
  logic [DW-1:0]   diff_nxt;
  logic [PW:0]     ysum;
  logic [SW-1:0]   sp1;
  logic [2*SW-1:0] mean_prod;

  assign dr_nxt   = channel_order_i ? lut[pixel_i.channel_zero] : lut[pixel_i.channel_two];
  assign db_nxt   = channel_order_i ? lut[pixel_i.channel_two]  : lut[pixel_i.channel_zero];
  assign s_nxt    = SW'(a_dr_r) + SW'(a_dg_r) + SW'(a_db_r);
  assign dr3      = {1'b0, a_dr_r, 1'b0} + (DW+2)'(a_dr_r);
  assign neg_nxt  = (a_dg_r < a_db_r);
  assign diff_nxt = neg_nxt ? (a_db_r - a_dg_r) : (a_dg_r - a_db_r);
  assign ysum     = (PW+1)'(b_mag_r) + ((PW+1)'(b_s_r) << (K - 1));
  assign sp1      = b_s_r + SW'(1);
  assign mean_prod = (2*SW)'(sp1) * (2*SW)'(MEAN_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= valid_i;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_dr_r   <= dr_nxt;
    a_dg_r   <= lut[pixel_i.channel_one];
    a_db_r   <= db_nxt;
    b_s_r    <= s_nxt;
    b_xnum_r <= (RW'(dr3) << FRAC_BITS) + RW'(s_nxt >> 1);
    b_neg_r  <= neg_nxt;
    b_mag_r  <= PW'(diff_nxt) * PW'(SQRT3_Q30);
    c_s_r    <= b_s_r;
    c_sp1_r  <= sp1;
    c_q0_r   <= mean_prod[2*SW-1:SW];
    c_xnum_r <= b_xnum_r;
    c_ynum_r <= RW'(ysum >> K);
    c_neg_r  <= b_neg_r;
  end

  assign valid_o = c_valid_r;
  assign xnum_o  = c_xnum_r;
  assign ynum_o  = c_ynum_r;
  assign dsh_o   = RW'(c_s_r) << (QW - 1);
  assign side_o  = {c_neg_r, c_sp1_r, c_q0_r};

endmodule

/* hw/rtl/rgb_to_hsd_density.sv */
// Top level of the RGB to HSD density transform: front pipeline, division
// chain and output register. Depends on rgbhsd_pkg, rgbhsd_front, rgbhsd_div_cell.
//
//   port group   direction  handshake            payload
//   in_*         in         start / busy         in_pixel  (pixel_t)
//   out_*        out        out_valid strobe     out_result (hsd_t)
//   cfg_*        in         cfg_valid/cfg_ready  cfg_data (channel order bit)
//
// One pixel enters every cycle; busy stays low. A beat passes FRAC_BITS + 6
// registers: three front stages, one division cell per quotient bit
// (FRAC_BITS + 2 cells), one output register.
// Synchronous active-low reset clears the valid bits and the channel order.
// The receiver cannot stall, so nothing in the pipe ever holds.
`include "assert_macros.svh"

module rgb_to_hsd_density #(
  parameter int FRAC_BITS = rgbhsd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rgbhsd_pkg::pixel_t in_pixel,
  output logic               out_valid,
  output rgbhsd_pkg::hsd_t   out_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import rgbhsd_pkg::*;

  localparam int DW  = FRAC_BITS + 3;
  localparam int SW  = DW + 2;
  localparam int QW  = FRAC_BITS + 2;
  localparam int RW  = SW + QW;
  localparam int SBW = 2 * SW + 1;
  localparam int MW  = (SW > 17) ? SW : 17;
  localparam int EW  = (QW + 2 > 17) ? QW + 2 : 17;
  localparam int LAT = QW + 4;
  localparam int CX_MIN = (FRAC_BITS > 15) ? -32768 : -(2 ** FRAC_BITS);
  localparam logic signed [EW-1:0] SMAX = EW'(32767);
  localparam logic signed [EW-1:0] SMIN = EW'(-32768);

  logic channel_order_r;
  logic in_accept;

  // The pipe never stalls: take every start and every config beat.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_order_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      channel_order_r <= cfg_data;
    end
  end

  // Chain links: index 0 is fed by the front, index QW leaves the last cell.
  logic           lk_valid [QW+1];
  logic [RW-1:0]  lk_dsh   [QW+1];
  logic [RW-1:0]  lk_rx    [QW+1];
  logic [RW-1:0]  lk_ry    [QW+1];
  logic [QW-1:0]  lk_qx    [QW+1];
  logic [QW-1:0]  lk_qy    [QW+1];
  logic [SBW-1:0] lk_side  [QW+1];

  rgbhsd_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid_i         (in_accept),
    .pixel_i         (in_pixel),
    .channel_order_i (channel_order_r),
    .valid_o         (lk_valid[0]),
    .xnum_o          (lk_rx[0]),
    .ynum_o          (lk_ry[0]),
    .dsh_o           (lk_dsh[0]),
    .side_o          (lk_side[0])
  );

  assign lk_qx[0] = '0;
  assign lk_qy[0] = '0;

  // One cell per quotient bit, most significant first; the shifted divisor
  // travels with the beat so every cell is the same.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    rgbhsd_div_cell #(
      .RW  (RW),
      .QW  (QW),
      .SBW (SBW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (lk_valid[i]),
      .dsh_i   (lk_dsh[i]),
      .rx_i    (lk_rx[i]),
      .ry_i    (lk_ry[i]),
      .qx_i    (lk_qx[i]),
      .qy_i    (lk_qy[i]),
      .side_i  (lk_side[i]),
      .valid_o (lk_valid[i+1]),
      .dsh_o   (lk_dsh[i+1]),
      .rx_o    (lk_rx[i+1]),
      .ry_o    (lk_ry[i+1]),
      .qx_o    (lk_qx[i+1]),
      .qy_o    (lk_qy[i+1]),
      .side_o  (lk_side[i+1])
    );
  end

  // Unpack the side band at the chain exit.
  logic          t_neg;
  logic [SW-1:0] t_sp1, t_q0;
  assign {t_neg, t_sp1, t_q0} = lk_side[QW];

  // Mean: the reciprocal estimate is at most one short; correct it once.
  logic [SW+1:0] q0x3;
  logic [SW+1:0] mean_rem;
  logic [MW-1:0] mean_full;
  assign q0x3      = {t_q0, 1'b0} + (SW+2)'(t_q0);
  assign mean_rem  = (SW+2)'(t_sp1) - q0x3;
  assign mean_full = MW'(t_q0) + MW'(mean_rem >= (SW+2)'(3));

  // Chroma: drop the unit offset from x, apply the sign to y, then clip.
  logic signed [EW-1:0] cx_full, cy_full;
  assign cx_full = $signed(EW'(lk_qx[QW])) - $signed(EW'(1) << FRAC_BITS);
  assign cy_full = t_neg ? -$signed(EW'(lk_qy[QW])) : $signed(EW'(lk_qy[QW]));

  logic [15:0]          mean_sat;
  logic signed [EW-1:0] cx_sat, cy_sat;

  always_comb begin
    mean_sat = (mean_full > MW'(16'hFFFF)) ? 16'hFFFF : mean_full[15:0];
    priority if (cx_full > SMAX) cx_sat = SMAX;
    else if (cx_full < SMIN)     cx_sat = SMIN;
    else                         cx_sat = cx_full;
    priority if (cy_full > SMAX) cy_sat = SMAX;
    else if (cy_full < SMIN)     cy_sat = SMIN;
    else                         cy_sat = cy_full;
  end

  logic out_valid_r;
  hsd_t out_result_r;
  hsd_t out_result_nxt;

  always_comb begin
    out_result_nxt.mean_density = mean_sat;
    out_result_nxt.chroma_x     = cx_sat[15:0];
    out_result_nxt.chroma_y     = cy_sat[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= lk_valid[QW];
    end
  end

  // Result payload needs no reset; the strobe qualifies it.
  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  `ASSERT_CLK(a_fixed_latency, clk, rst_n, out_valid |-> $past(in_accept, LAT), "result strobe without a pixel taken LAT cycles earlier")
  `ASSERT_CLK(a_rem_below_div, clk, rst_n, lk_valid[QW] |-> ((lk_rx[QW] < (RW'(t_sp1) - RW'(1))) && (lk_ry[QW] < (RW'(t_sp1) - RW'(1)))), "division remainder not below the density sum")
  `ASSERT_NEVER(a_cx_floor, clk, rst_n, out_valid && (int'(out_result.chroma_x) < CX_MIN), "chroma_x below its lowest reachable value")

endmodule
